[src/utf8_byte_stream_decoder_top_assert.svh]
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UTF8D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// types and constants shared by the utf8 byte stream decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int PAY_W  = 6;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(63);

  // sequence length codes, none when no sequence is open
  typedef enum logic [2:0] {
    SEQ_NONE = 3'd0,
    SEQ_2    = 3'd2,
    SEQ_3    = 3'd3,
    SEQ_4    = 3'd4,
    SEQ_5    = 3'd5,
    SEQ_6    = 3'd6
  } seq_len_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_text;
  } byte_item_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
  } result_t;

  // replace overlong forms and surrogates
  function automatic logic [CP_W-1:0] check_value(seq_len_t len, logic [CP_W-1:0] v);
    logic bad;
    bad = 1'b0;
    unique case (len)
      SEQ_2:   bad = (v[CP_W-1:7] == '0);
      SEQ_3:   bad = (v[CP_W-1:11] == '0) ||
                     ((v[CP_W-1:16] == '0) && (v[15:11] == 5'b11011));
      SEQ_4:   bad = (v[CP_W-1:16] == '0);
      SEQ_5:   bad = (v[CP_W-1:21] == '0);
      SEQ_6:   bad = (v[CP_W-1:26] == '0);
      default: bad = 1'b0;
    endcase
    return bad ? REPLACEMENT_CP : v;
  endfunction

endpackage

[src/utf8d_byte_if.sv]
// ----------------------------------------------------------------------------
// utf8d_byte_if
// byte channel: valid/ready with one text byte and end-of-text flag
// ----------------------------------------------------------------------------
interface utf8d_byte_if import utf8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

[src/utf8d_cp_if.sv]
// ----------------------------------------------------------------------------
// utf8d_cp_if
// code point channel: valid/ready with one decoded code point
// ----------------------------------------------------------------------------
interface utf8d_cp_if import utf8d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

[src/utf8d_in_stage.sv]
// ----------------------------------------------------------------------------
// utf8d_in_stage
// input register for the byte channel
// ----------------------------------------------------------------------------
module utf8d_in_stage import utf8d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  utf8d_byte_if.sink   byte_in,
  input  logic         free,
  output logic         fire,
  output byte_item_t   item
);

  logic       held;
  byte_item_t item_reg;

  assign fire          = held && free;
  assign byte_in.ready = !held || free;
  assign item          = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_in.ready) begin
      held <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      item_reg.data_byte   <= byte_in.data_byte;
      item_reg.end_of_text <= byte_in.end_of_text;
    end
  end

endmodule

[src/utf8d_decode.sv]
// ----------------------------------------------------------------------------
// utf8d_decode
// sequence state and one-byte decode step
// ----------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_top_assert.svh"

module utf8d_decode import utf8d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  byte_item_t item,
  output result_t    res
);

  logic [2:0]      bytes_remaining, bytes_remaining_next;
  seq_len_t        sequence_length, sequence_length_next;
  logic [CP_W-1:0] accumulated_value, accumulated_value_next;
  logic [CP_W-1:0] shifted;
  logic [2:0]      rem_dec;
  logic [BYTE_W-1:0] b;

  assign b       = item.data_byte;
  assign shifted = {accumulated_value[CP_W-PAY_W-1:0], b[PAY_W-1:0]};
  assign rem_dec = bytes_remaining - 3'd1;

  always_comb begin
    bytes_remaining_next   = bytes_remaining;
    sequence_length_next   = sequence_length;
    accumulated_value_next = accumulated_value;
    res.emit       = 1'b0;
    res.code_point = CP_W'(b);
    if (bytes_remaining == 3'd0) begin
      priority if (!b[7]) begin
        res.emit = (b != '0);
      end else if (b[7:5] == 3'b110) begin
        sequence_length_next   = SEQ_2;
        bytes_remaining_next   = 3'd1;
        accumulated_value_next = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        sequence_length_next   = SEQ_3;
        bytes_remaining_next   = 3'd2;
        accumulated_value_next = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        sequence_length_next   = SEQ_4;
        bytes_remaining_next   = 3'd3;
        accumulated_value_next = CP_W'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
        sequence_length_next   = SEQ_5;
        bytes_remaining_next   = 3'd4;
        accumulated_value_next = CP_W'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
        sequence_length_next   = SEQ_6;
        bytes_remaining_next   = 3'd5;
        accumulated_value_next = CP_W'(b[0]);
      end else begin
        // stray continuation, 0xfe or 0xff: dropped
        res.emit = 1'b0;
      end
    end else begin
      // continuation top bits are not checked
      accumulated_value_next = shifted;
      bytes_remaining_next   = rem_dec;
      if (rem_dec == 3'd0) begin
        res.emit               = 1'b1;
        res.code_point         = check_value(sequence_length, shifted);
        sequence_length_next   = SEQ_NONE;
        accumulated_value_next = '0;
      end
    end
    if (item.end_of_text) begin
      bytes_remaining_next   = 3'd0;
      sequence_length_next   = SEQ_NONE;
      accumulated_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining   <= 3'd0;
      sequence_length   <= SEQ_NONE;
      accumulated_value <= '0;
    end else if (fire) begin
      bytes_remaining   <= bytes_remaining_next;
      sequence_length   <= sequence_length_next;
      accumulated_value <= accumulated_value_next;
    end
  end

  `UTF8D_ASSERT_SAME(a_open_has_len, clk, rst, bytes_remaining != 3'd0,
    (sequence_length != SEQ_NONE) && (bytes_remaining < sequence_length),
    "open sequence without a consistent length")
  `UTF8D_ASSERT_SAME(a_idle_no_len, clk, rst, bytes_remaining == 3'd0,
    (sequence_length == SEQ_NONE) && (accumulated_value == '0),
    "idle decoder holds stale sequence state")
  `UTF8D_ASSERT_NEXT(a_eot_clears, clk, rst, fire && item.end_of_text,
    bytes_remaining == 3'd0, "end of text left a sequence open")
  `UTF8D_ASSERT_SAME(a_cp_nonzero, clk, rst, fire && res.emit,
    res.code_point != '0, "zero code point emitted")

endmodule

[src/utf8d_out_stage.sv]
// ----------------------------------------------------------------------------
// utf8d_out_stage
// result register for the code point channel
// ----------------------------------------------------------------------------
module utf8d_out_stage import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  result_t     res,
  utf8d_cp_if.source  cp_out,
  output logic        free
);

  logic            full;
  logic [CP_W-1:0] code_point;

  assign free              = !full || cp_out.ready;
  assign cp_out.valid      = full;
  assign cp_out.code_point = code_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (free && fire && res.emit) begin
      code_point <= res.code_point;
    end
  end

endmodule

[src/utf8_byte_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// utf8 byte stream decoder, legacy six-byte form with 31-bit code points
// ----------------------------------------------------------------------------
//  channel   dir  payload                      width
//  byte_in   in   data_byte, end_of_text       8 + 1
//  cp_out    out  code_point                   31
//
//  one byte per clock unless cp_out stalls; a code point is valid on cp_out once
//  its last byte has passed input register, decode step and result register
//  rst is synchronous: the open sequence is dropped and both registers empty
//  cp_out stalls hold the result register and, once the input register is
//  also full, back-pressure byte_in; no bytes are lost
//  bytes that end no sequence give no item on cp_out
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top import utf8d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  utf8d_byte_if.sink byte_in,
  utf8d_cp_if.source cp_out
);

  logic       free;
  logic       fire;
  byte_item_t item;
  result_t    res;

  utf8d_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .free    (free),
    .fire    (fire),
    .item    (item)
  );

  utf8d_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  utf8d_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .res    (res),
    .cp_out (cp_out),
    .free   (free)
  );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the utf8 byte stream decoder against a cycle-free prediction of its
// decoding: directed edge cases, then random text with clean, overlong,
// surrogate and malformed sequences; bursty sender, stalling receiver
// ----------------------------------------------------------------------------
module testbench;
  import utf8d_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TEXT_BYTES  = 1950;
  localparam int HOLD_CYCLES = 400;

  // first bytes: ascii extremes, shortest two-byte, overlong, surrogate, top of
  // unicode, stray bytes, largest 31-bit value, cut-off sequence, ascii at end
  localparam int DIR_N = 25;
  localparam logic [DIR_N*8-1:0] DIRECTED_TEXT = {
    8'h01, 8'h7F, 8'hC2, 8'h80, 8'hC1, 8'hBF, 8'hED, 8'hBF, 8'hBF,
    8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFE, 8'hFF,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hF8, 8'h88, 8'h41
  };

  typedef enum int {FORM_CLEAN, FORM_OVERLONG, FORM_SURROGATE, FORM_NOISE} seq_form_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  utf8d_byte_if byte_in ();
  utf8d_cp_if   cp_out ();

  utf8_byte_stream_decoder_top u_top (
    .clk    (clk),
    .rst    (rst),
    .byte_in(byte_in),
    .cp_out (cp_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_item_t      text_queue [$];
  logic [CP_W-1:0] expected_cps [$];

  // decoder state as predicted
  logic [2:0]      bytes_left;
  seq_len_t        open_len;
  logic [CP_W-1:0] acc_value;

  int bad_count, cps_checked, replacements, cut_off, bytes_sent;
  logic in_fire, out_fire;
  int idle_cycles;

  task automatic push_byte(input logic [7:0] b, input logic eot);
    byte_item_t it;
    it.data_byte   = b;
    it.end_of_text = eot;
    text_queue.push_back(it);
  endtask

  // one sequence of len bytes; eot_at is the index carrying end of text, -1 for none
  task automatic add_sequence(input int len, input seq_form_t form, input int eot_at);
    logic [7:0] b;
    logic [7:0] prefix, xmask;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        if (len == 1) begin
          b = 8'($urandom_range(1, 127));
        end else begin
          prefix = 8'hFF << (8 - len);
          xmask  = 8'hFF >> (len + 1);
          if (form == FORM_SURROGATE) b = 8'hED;
          else if (form == FORM_OVERLONG) b = prefix | ((len == 2) ? 8'($urandom_range(0, 1)) : 8'h00);
          else b = prefix | (8'($urandom) & xmask);
        end
      end else if (form == FORM_NOISE) begin
        b = 8'($urandom_range(1, 255));
      end else if (i == 1 && form == FORM_SURROGATE) begin
        b = 8'hA0 | (8'($urandom) & 8'h1F);
      end else if (i == 1 && form == FORM_OVERLONG && len > 2) begin
        b = 8'h80 | (8'($urandom) & (8'h3F >> (len - 2)));
      end else begin
        b = 8'h80 | (8'($urandom) & 8'h3F);
      end
      push_byte(b, i == eot_at);
    end
  endtask

  // expected code points for one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [CP_W-1:0] floor_value;
    logic            bad;
    if (bytes_left == 3'd0) begin
      if (b < 8'h80) begin
        if (b != 8'h00) expected_cps.push_back(CP_W'(b));
      end else if (b[7:5] == 3'b110) begin
        open_len = SEQ_2; bytes_left = 3'd1; acc_value = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        open_len = SEQ_3; bytes_left = 3'd2; acc_value = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        open_len = SEQ_4; bytes_left = 3'd3; acc_value = CP_W'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
        open_len = SEQ_5; bytes_left = 3'd4; acc_value = CP_W'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
        open_len = SEQ_6; bytes_left = 3'd5; acc_value = CP_W'(b[0]);
      end
    end else begin
      // top bits of the continuation are not looked at
      acc_value  = {acc_value[CP_W-7:0], b[5:0]};
      bytes_left = bytes_left - 3'd1;
      if (bytes_left == 3'd0) begin
        case (open_len)
          SEQ_2:   floor_value = CP_W'('h80);
          SEQ_3:   floor_value = CP_W'('h800);
          SEQ_4:   floor_value = CP_W'('h10000);
          SEQ_5:   floor_value = CP_W'('h200000);
          SEQ_6:   floor_value = CP_W'('h4000000);
          default: floor_value = '0;
        endcase
        bad = (acc_value < floor_value) ||
              (open_len == SEQ_3 && acc_value >= CP_W'('hD800) && acc_value <= CP_W'('hDFFF));
        if (bad) replacements++;
        expected_cps.push_back(bad ? REPLACEMENT_CP : acc_value);
        open_len  = SEQ_NONE;
        acc_value = '0;
      end
    end
    if (eot) begin
      if (bytes_left != 3'd0) cut_off++;
      bytes_left = 3'd0;
      open_len   = SEQ_NONE;
      acc_value  = '0;
    end
  endtask

  // handshake sampling, prediction and comparison
  always @(posedge clk) begin
    in_fire  = !rst && byte_in.valid && byte_in.ready;
    out_fire = !rst && cp_out.valid && cp_out.ready;
    if (out_fire) begin
      if (expected_cps.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("unexpected code point %h", cp_out.code_point);
      end else begin
        if (cp_out.code_point !== expected_cps[0]) begin
          bad_count++;
          if (bad_count <= 10)
            $display("code point mismatch: expected %h got %h", expected_cps[0],
                     cp_out.code_point);
        end
        void'(expected_cps.pop_front());
        cps_checked++;
      end
    end
    if (in_fire) begin
      bytes_sent++;
      decode_byte(byte_in.data_byte, byte_in.end_of_text);
    end
  end

  // sender: bursts of items with gaps between them
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin
    byte_item_t it;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_in.valid <= 1'b0;
      end else if (text_queue.size() > 0) begin
        it = text_queue.pop_front();
        byte_in.valid       <= 1'b1;
        byte_in.data_byte   <= it.data_byte;
        byte_in.end_of_text <= it.end_of_text;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, plus long hold-offs
  int       recv_cycle = 0;
  int       hold_left  = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;
  always @(negedge clk) begin
    if (rst) begin
      cp_out.ready <= 1'b0;
    end else begin
      recv_cycle++;
      if (recv_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      // sender keeps offering during these, so the decoder fills and stalls
      if (recv_cycle == 1200 || recv_cycle == 2800) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        cp_out.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: cp_out.ready <= 1'b1;
          RX_COIN:   cp_out.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: cp_out.ready <= (recv_cycle % 4 == 0);
          default:   cp_out.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stalled with %0d bytes unsent, %0d code points outstanding",
                 text_queue.size(), expected_cps.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick, len, eot_at;
    rst                 = 1'b1;
    byte_in.valid       = 1'b0;
    byte_in.data_byte   = '0;
    byte_in.end_of_text = 1'b0;
    cp_out.ready        = 1'b0;
    bytes_left  = 3'd0;
    open_len    = SEQ_NONE;
    acc_value   = '0;
    bad_count   = 0;
    cps_checked = 0;
    replacements = 0;
    cut_off     = 0;
    bytes_sent  = 0;
    idle_cycles = 0;
    in_fire     = 1'b0;
    out_fire    = 1'b0;

    for (int i = 0; i < DIR_N; i++)
      push_byte(DIRECTED_TEXT[(DIR_N-1-i)*8 +: 8], i >= DIR_N - 2);

    while (text_queue.size() < TEXT_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len    = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 6);
        eot_at = ($urandom_range(0, 15) == 0) ? len - 1 : -1;
        add_sequence(len, FORM_CLEAN, eot_at);
      end else if (pick < 70) begin
        len = $urandom_range(2, 6);
        add_sequence(len, FORM_OVERLONG, -1);
      end else if (pick < 75) begin
        add_sequence(3, FORM_SURROGATE, -1);
      end else if (pick < 88) begin
        // truncated or with arbitrary trailing bytes
        len    = $urandom_range(2, 6);
        eot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : -1;
        add_sequence(len, FORM_NOISE, eot_at);
      end else begin
        push_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || byte_in.valid) @(posedge clk);
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d text bytes decoded, %0d code points compared, %0d of them replacements",
             bytes_sent, cps_checked, replacements);
    $display("%0d open sequences dropped at end of text; %0d mismatches",
             cut_off, bad_count);
    if (bad_count == 0 && expected_cps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/utf8d_pkg.sv
src/utf8d_byte_if.sv
src/utf8d_cp_if.sv
src/utf8d_in_stage.sv
src/utf8d_decode.sv
src/utf8d_out_stage.sv
src/utf8_byte_stream_decoder_top.sv
tb/testbench.sv
